/* design/anhd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package anhd_pkg;

    localparam int TABLE_DEPTH = 1280;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int ROW_SIZE    = 256;
    localparam int ROW_COUNT   = TABLE_DEPTH / ROW_SIZE;

    localparam logic [31:0] HASH_INIT_A = 32'h7FED7FED;
    localparam logic [31:0] SEED_INIT_B = 32'hEEEEEEEE;
    localparam logic [31:0] ROT_ADD     = 32'h11111111;
    localparam logic [31:0] GEN_START   = 32'h00100001;
    localparam logic [31:0] GEN_MOD     = 32'h002AAAAB;
    localparam logic [31:0] GEN_MUL     = 32'd125;
    localparam logic [31:0] GEN_INC     = 32'd3;
    localparam logic [31:0] MIX_INC     = 32'd3;
    localparam logic [TABLE_AW-1:0] KEY_ROW = TABLE_AW'(32'h400);

    typedef logic [31:0] crypt_table_t [TABLE_DEPTH];

    typedef enum logic [1:0] {
        OP_HASH_BYTE   = 2'd0,
        OP_HASH_FINISH = 2'd1,
        OP_DECRYPT     = 2'd2,
        OP_NONE        = 2'd3
    } op_t;

    typedef struct packed {
        logic fire;
        logic start;
        op_t  op;
    } step_ctl_t;

    // Entry i + 256k takes two draws of the generator: upper half, then lower half.
    function automatic crypt_table_t build_crypt_table();
        crypt_table_t tab;
        logic [31:0]  s;
        logic [31:0]  hi;
        s  = GEN_START;
        hi = '0;
        for (int i = 0; i < ROW_SIZE; i++)
        begin
            for (int k = 0; k < ROW_COUNT; k++)
            begin
                s  = (s * GEN_MUL + GEN_INC) % GEN_MOD;
                hi = s;
                s  = (s * GEN_MUL + GEN_INC) % GEN_MOD;
                tab[i + ROW_SIZE * k] = {hi[15:0], s[15:0]};
            end
        end
        return tab;
    endfunction

    localparam crypt_table_t CRYPT_TABLE = build_crypt_table();

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/anhd_hash_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module anhd_hash_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire anhd_pkg::step_ctl_t ctl,
    input  wire logic [7:0]          char_in,
    input  wire logic [31:0]         entry,
    output logic [31:0]              hash_value
);
    import anhd_pkg::*;

    logic [31:0] seed_a_reg;
    logic [31:0] seed_a_next;
    logic [31:0] seed_b_reg;
    logic [31:0] seed_b_next;
    logic [31:0] base_a;
    logic [31:0] base_b;
    logic [31:0] mixed_a;
    logic [31:0] mixed_b;

    always_comb
    begin
        base_a  = ctl.start ? HASH_INIT_A : seed_a_reg;
        base_b  = ctl.start ? SEED_INIT_B : seed_b_reg;
        mixed_a = entry ^ (base_a + base_b);
        mixed_b = {24'd0, char_in} + mixed_a + base_b + (base_b << 5) + MIX_INC;
    end

    always_comb
    begin
        seed_a_next = seed_a_reg;
        seed_b_next = seed_b_reg;
        if (ctl.fire)
        begin
            unique case (ctl.op)
                OP_HASH_BYTE:
                begin
                    seed_a_next = mixed_a;
                    seed_b_next = mixed_b;
                end
                OP_HASH_FINISH:
                begin
                    seed_a_next = HASH_INIT_A;
                    seed_b_next = SEED_INIT_B;
                end
                default:
                begin
                    seed_a_next = seed_a_reg;
                    seed_b_next = seed_b_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_a_reg <= HASH_INIT_A;
            seed_b_reg <= SEED_INIT_B;
        end
        else
        begin
            seed_a_reg <= seed_a_next;
            seed_b_reg <= seed_b_next;
        end
    end

    assign hash_value = base_a;

endmodule

`default_nettype wire

/* design/anhd_crypt_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module anhd_crypt_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                key_we,
    input  wire logic [31:0]         key_in,
    input  wire anhd_pkg::step_ctl_t ctl,
    input  wire logic [31:0]         cipher,
    output logic [31:0]              plain
);
    import anhd_pkg::*;

    logic [31:0] key_reg;
    logic [31:0] key_next;
    logic [31:0] key_ent_reg;
    logic [31:0] seed_a_reg;
    logic [31:0] seed_a_next;
    logic [31:0] seed_b_reg;
    logic [31:0] seed_b_next;
    logic [31:0] ent_reg;
    logic [31:0] base_a;
    logic [31:0] base_b;
    logic [31:0] base_ent;
    logic [31:0] sum_b;
    logic [31:0] rot_a;
    logic        fire_dec;

    // ent_reg always holds the key-row entry for seed_a_reg, key_ent_reg the one for key_reg.
    always_comb
    begin
        fire_dec = ctl.fire && (ctl.op == OP_DECRYPT);
        base_a   = ctl.start ? key_reg : seed_a_reg;
        base_b   = ctl.start ? SEED_INIT_B : seed_b_reg;
        base_ent = ctl.start ? key_ent_reg : ent_reg;
        sum_b    = base_b + base_ent;
        plain    = cipher ^ (base_a + sum_b);
        rot_a    = (((~base_a) << 21) + ROT_ADD) | (base_a >> 11);

        seed_a_next = fire_dec ? rot_a : seed_a_reg;
        seed_b_next = fire_dec ? (plain + sum_b + (sum_b << 5) + MIX_INC) : seed_b_reg;
        key_next    = key_we ? key_in : key_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg     <= '0;
            key_ent_reg <= CRYPT_TABLE[KEY_ROW];
            seed_a_reg  <= '0;
            seed_b_reg  <= SEED_INIT_B;
            ent_reg     <= CRYPT_TABLE[KEY_ROW];
        end
        else
        begin
            key_reg     <= key_next;
            key_ent_reg <= CRYPT_TABLE[KEY_ROW | {{(TABLE_AW-8){1'b0}}, key_next[7:0]}];
            seed_a_reg  <= seed_a_next;
            seed_b_reg  <= seed_b_next;
            ent_reg     <= CRYPT_TABLE[KEY_ROW | {{(TABLE_AW-8){1'b0}}, seed_a_next[7:0]}];
        end
    end

endmodule

`default_nettype wire

/* design/archive_name_hash_and_decrypt.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals                       Contents
// s_*       in         tvalid tready tdata tuser     data / operation, hash_type, start_req
// m_*       out        tvalid tready tdata tuser     value / kind
// cfg_*     in         valid ready data              decrypt_key
//
// Two register stages: input stage (name byte uppercased, hash table entry read),
// then seed update into the output register. One transaction per cycle while the output is not stalled.
// Asynchronous active-low reset; seeds and key return to their initial values.
// A stalled output holds the pipeline; the input stage still fills while it is empty.
module archive_name_hash_and_decrypt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] data
    input  wire logic [4:0]  s_tuser,   // [1:0] operation, [3:2] hash_type, [4] start_req
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] value
    output logic             m_tuser,   // [0] kind
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);
    import anhd_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    op_t         s1_op_reg;
    logic        s1_start_reg;
    logic [7:0]  s1_char_reg;
    logic [31:0] s1_ent_reg;
    logic [31:0] s1_data_reg;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [31:0] m_value_reg;
    logic [31:0] m_value_next;
    logic        m_kind_reg;
    logic        m_kind_next;
    logic        s_fire;
    logic        s1_move;
    logic        out_free;
    logic        cfg_we;
    logic [7:0]  in_char;
    step_ctl_t   step_ctl;
    logic [31:0] hash_value;
    logic [31:0] plain;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    assign out_free = !m_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || s1_move;
    assign s_fire   = s_tvalid && s_tready;
    assign in_char  = to_upper(s_tdata[7:0]);

    assign step_ctl.fire  = s1_move;
    assign step_ctl.start = s1_start_reg;
    assign step_ctl.op    = s1_op_reg;

    anhd_hash_unit u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (step_ctl),
        .char_in    (s1_char_reg),
        .entry      (s1_ent_reg),
        .hash_value (hash_value)
    );

    anhd_crypt_unit u_crypt (
        .clk    (clk),
        .rst_n  (rst_n),
        .key_we (cfg_we),
        .key_in (cfg_data),
        .ctl    (step_ctl),
        .cipher (s1_data_reg),
        .plain  (plain)
    );

    always_comb
    begin
        s1_valid_next = s_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        m_valid_next  = m_valid_reg;
        m_value_next  = m_value_reg;
        m_kind_next   = m_kind_reg;
        if (out_free)
        begin
            m_valid_next = 1'b0;
        end
        if (s1_move)
        begin
            unique case (s1_op_reg)
                OP_HASH_FINISH:
                begin
                    m_valid_next = 1'b1;
                    m_value_next = hash_value;
                    m_kind_next  = 1'b1;
                end
                OP_DECRYPT:
                begin
                    m_valid_next = 1'b1;
                    m_value_next = plain;
                    m_kind_next  = 1'b0;
                end
                default:
                begin
                    m_valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_op_reg    <= op_t'(s_tuser[1:0]);
            s1_start_reg <= s_tuser[4];
            s1_char_reg  <= in_char;
            s1_ent_reg   <= CRYPT_TABLE[{1'b0, s_tuser[3:2], in_char}];
            s1_data_reg  <= s_tdata;
        end
        m_value_reg <= m_value_next;
        m_kind_reg  <= m_kind_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_kind_reg;

    a_finish_gives_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_op_reg == OP_HASH_FINISH) |=> (m_valid_reg && m_kind_reg))
        else $error("finish transaction did not produce a hash result");

    a_decrypt_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_op_reg == OP_DECRYPT) |=> (m_valid_reg && !m_kind_reg))
        else $error("decrypt transaction did not produce a plain word");

    a_silent_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && (s1_op_reg == OP_HASH_BYTE || s1_op_reg == OP_NONE)) |=> !m_valid_reg)
        else $error("result produced by a transaction without output");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> s1_valid_reg)
        else $error("input stage lost a transaction under stall");

endmodule

`default_nettype wire

/* tb/sv/archive_name_hash_and_decrypt_tb.sv */
`timescale 1ns / 1ps

module archive_name_hash_and_decrypt_tb;

    import anhd_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int PHASE_COUNT     = 5;
    localparam int SETTLE_CYCLES   = 8;

    class anhd_scoreboard;
        logic [31:0] crypt_rom [TABLE_DEPTH];
        logic [31:0] decrypt_key;
        logic [31:0] name_seed_a;
        logic [31:0] name_seed_b;
        logic [31:0] word_seed_a;
        logic [31:0] word_seed_b;
        logic [31:0] expected_value [$];
        bit          expected_kind [$];
        int unsigned errors;

        function new();
            logic [31:0] draw;
            logic [31:0] upper;
            draw = GEN_START;
            for (int i = 0; i < ROW_SIZE; i++)
            begin
                for (int k = 0; k < ROW_COUNT; k++)
                begin
                    draw  = (draw * GEN_MUL + GEN_INC) % GEN_MOD;
                    upper = draw;
                    draw  = (draw * GEN_MUL + GEN_INC) % GEN_MOD;
                    crypt_rom[i + ROW_SIZE * k] = {upper[15:0], draw[15:0]};
                end
            end
            decrypt_key = '0;
            name_seed_a = HASH_INIT_A;
            name_seed_b = SEED_INIT_B;
            word_seed_a = '0;
            word_seed_b = SEED_INIT_B;
            errors      = 0;
        endfunction

        function void set_key(input logic [31:0] key);
            decrypt_key = key;
        endfunction

        function void queue_result(input logic [31:0] value, input bit kind);
            expected_value = {expected_value, value};
            expected_kind  = {expected_kind, kind};
        endfunction

        function void take_item(input op_t op, input logic [1:0] hash_type,
                                input logic [31:0] data, input bit start);
            logic [7:0]  ch;
            logic [31:0] plain;
            case (op)
                OP_HASH_BYTE, OP_HASH_FINISH:
                begin
                    if (start)
                    begin
                        name_seed_a = HASH_INIT_A;
                        name_seed_b = SEED_INIT_B;
                    end
                    if (op == OP_HASH_BYTE)
                    begin
                        ch = data[7:0];
                        if (ch >= 8'h61 && ch <= 8'h7A)
                        begin
                            ch = ch - 8'h20;
                        end
                        name_seed_a = crypt_rom[{hash_type, ch}] ^ (name_seed_a + name_seed_b);
                        name_seed_b = 32'(ch) + name_seed_a + name_seed_b + (name_seed_b << 5)
                                      + MIX_INC;
                    end
                    else
                    begin
                        queue_result(name_seed_a, 1'b1);
                        name_seed_a = HASH_INIT_A;
                        name_seed_b = SEED_INIT_B;
                    end
                end
                OP_DECRYPT:
                begin
                    if (start)
                    begin
                        word_seed_a = decrypt_key;
                        word_seed_b = SEED_INIT_B;
                    end
                    word_seed_b = word_seed_b + crypt_rom[KEY_ROW + word_seed_a[7:0]];
                    plain       = data ^ (word_seed_a + word_seed_b);
                    word_seed_a = (((~word_seed_a) << 21) + ROT_ADD) | (word_seed_a >> 11);
                    word_seed_b = plain + word_seed_b + (word_seed_b << 5) + MIX_INC;
                    queue_result(plain, 1'b0);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(input logic [31:0] value, input bit kind);
            logic [31:0] want_value;
            bit          want_kind;
            if (expected_value.size() == 0)
            begin
                $error("unexpected transaction: value %h kind %0d", value, kind);
                errors++;
                return;
            end
            want_value = expected_value.pop_front();
            want_kind  = expected_kind.pop_front();
            if (value !== want_value)
            begin
                $error("value mismatch: expected %h actual %h", want_value, value);
                errors++;
            end
            if (kind !== want_kind)
            begin
                $error("kind mismatch: expected %0d actual %0d", want_kind, kind);
                errors++;
            end
        endfunction

        function int pending();
            return expected_value.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [4:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    anhd_scoreboard board = new();
    bit             calm;
    int             sent_items;
    int             ready_hold;
    int             ready_pick;
    int             quiet_cycles;

    archive_name_hash_and_decrypt i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                board.set_key(cfg_data);
            end
            if (s_tvalid && s_tready)
            begin
                board.take_item(op_t'(s_tuser[1:0]), s_tuser[3:2], s_tdata, s_tuser[4]);
            end
            if (m_tvalid && m_tready)
            begin
                board.check_result(m_tdata, m_tuser);
            end
        end
    end

    // output back-pressure: mostly ready, short stalls, the odd long one
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else if (calm)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 70)
            begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(0, 20);
            end
            else if (ready_pick < 95)
            begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end
            else
            begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 55)
        begin
            return 0;
        end
        if (pick < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] name_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            return 8'h61 + 8'($urandom_range(0, 25));
        end
        if (pick < 60)
        begin
            return 8'h41 + 8'($urandom_range(0, 25));
        end
        if (pick < 70)
        begin
            return 8'h30 + 8'($urandom_range(0, 9));
        end
        if (pick < 80)
        begin
            case ($urandom_range(0, 2))
                0:       return 8'h2E;
                1:       return 8'h5C;
                default: return 8'h5F;
            endcase
        end
        return 8'($urandom);
    endfunction

    function automatic bit chance(input int percent);
        return $urandom_range(0, 99) < percent;
    endfunction

    task automatic send_item(input op_t op, input logic [1:0] hash_type,
                             input logic [31:0] data, input bit start);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= {start, hash_type, op};
        do @(posedge clk); while (!s_tready);
        if (op != OP_NONE)
        begin
            sent_items++;
        end
    endtask

    task automatic write_key(input logic [31:0] key);
        cfg_valid <= 1'b1;
        cfg_data  <= key;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // drain all expected results, then let trailing hash bytes clear the pipe
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_name();
        int         len;
        logic [1:0] name_type;
        len       = $urandom_range(1, 12);
        name_type = 2'($urandom_range(0, 3));
        for (int n = 0; n < len; n++)
        begin
            send_item(OP_HASH_BYTE, chance(15) ? 2'($urandom_range(0, 3)) : name_type,
                      {24'($urandom), name_char()}, (n == 0) ? chance(85) : chance(5));
        end
        send_item(OP_HASH_FINISH, 2'($urandom), $urandom, chance(10));
    endtask

    task automatic send_words();
        int len;
        len = $urandom_range(1, 8);
        for (int n = 0; n < len; n++)
        begin
            send_item(OP_DECRYPT, 2'($urandom), $urandom, (n == 0) ? chance(80) : chance(5));
        end
    endtask

    task automatic send_noise();
        int len;
        len = $urandom_range(1, 3);
        for (int n = 0; n < len; n++)
        begin
            send_item(OP_NONE, 2'($urandom), $urandom, 1'($urandom));
        end
    endtask

    // unterminated names and stray finishes
    task automatic send_broken();
        int len;
        if (chance(50))
        begin
            len = $urandom_range(1, 4);
            for (int n = 0; n < len; n++)
            begin
                send_item(OP_HASH_BYTE, 2'($urandom), $urandom, 1'($urandom));
            end
        end
        else
        begin
            send_item(OP_HASH_FINISH, 2'($urandom), $urandom, 1'($urandom));
        end
    endtask

    task automatic send_directed();
        send_item(OP_DECRYPT,     2'd0, 32'h00000000, 1'b0);
        send_item(OP_DECRYPT,     2'd3, 32'hFFFFFFFF, 1'b0);
        send_item(OP_HASH_FINISH, 2'd3, 32'hFFFFFFFF, 1'b1);
        send_item(OP_HASH_FINISH, 2'd0, 32'h00000000, 1'b0);
        send_item(OP_HASH_BYTE,   2'd0, 32'hFFFFFF61, 1'b1);
        send_item(OP_HASH_BYTE,   2'd1, 32'h0000007A, 1'b0);
        send_item(OP_HASH_BYTE,   2'd2, 32'hA5A5A560, 1'b0);
        send_item(OP_HASH_BYTE,   2'd3, 32'h5A5A5A7B, 1'b0);
        send_item(OP_HASH_BYTE,   2'd0, 32'h00000041, 1'b0);
        send_item(OP_HASH_BYTE,   2'd1, 32'h0000005A, 1'b0);
        send_item(OP_HASH_BYTE,   2'd2, 32'hFFFFFF00, 1'b0);
        send_item(OP_HASH_BYTE,   2'd3, 32'h000000FF, 1'b0);
        send_item(OP_HASH_FINISH, 2'd2, 32'h12345678, 1'b0);
        send_item(OP_NONE,        2'd3, 32'hFFFFFFFF, 1'b1);
        send_item(OP_HASH_BYTE,   2'd3, 32'h00000078, 1'b1);
        send_item(OP_HASH_FINISH, 2'd1, 32'h00000000, 1'b0);
        send_item(OP_DECRYPT,     2'd1, 32'h12345678, 1'b1);
        send_item(OP_DECRYPT,     2'd2, 32'hFFFFFFFF, 1'b0);
        send_item(OP_NONE,        2'd0, 32'h00000000, 1'b1);
        send_item(OP_DECRYPT,     2'd0, 32'h00000000, 1'b0);
        send_item(OP_HASH_BYTE,   2'd0, 32'h00000071, 1'b0);
        send_item(OP_HASH_FINISH, 2'd0, 32'h00000000, 1'b1);
    endtask

    function automatic logic [31:0] phase_key(input int phase);
        case (phase)
            0:       return 32'hFFFFFFFF;
            1:       return 32'h00000000;
            3:       return 32'h80000001;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int pick;
        int target;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        calm       = 1'b0;
        sent_items = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase > 0)
            begin
                settle();
            end
            write_key(phase_key(phase));
            calm = (phase == 2);
            if (phase == 0)
            begin
                send_directed();
            end
            target = sent_items + ITEMS_PER_PHASE;
            while (sent_items < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    send_name();
                end
                else if (pick < 85)
                begin
                    send_words();
                end
                else if (pick < 95)
                begin
                    send_noise();
                end
                else
                begin
                    send_broken();
                end
            end
        end
        settle();
        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* archive_name_hash_and_decrypt.f */
design/anhd_pkg.sv
design/anhd_hash_unit.sv
design/anhd_crypt_unit.sv
design/archive_name_hash_and_decrypt.sv
tb/sv/archive_name_hash_and_decrypt_tb.sv
